>>> rtl/bcm_pkg.sv
// Shared types and constants for the branch coverage bitmap update block.
`default_nettype none
package bcm_pkg;

   localparam int ATOMS_PER_BLOCK = 16;
   localparam int MAP_INDEX_BITS  = 16;
   localparam int MAP_ADDR_BITS   = 16;
   localparam int MAP_DEPTH       = 1 << MAP_ADDR_BITS;
   localparam int COUNT_BITS      = 5;
   localparam int CSR_ADDR_BITS   = 5;
   localparam int CSR_DATA_BITS   = 64;

   localparam logic [MAP_ADDR_BITS-1:0] IDX_MASK =
      MAP_ADDR_BITS'((1 << MAP_INDEX_BITS) - 1);
   localparam logic [7:0] ATOM_CLAMP = 8'd5;

   typedef enum logic [1:0] {
      OP_ATOM   = 2'd0,
      OP_BRANCH = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      REG_ENTRY_ADDRESS = 2'd0,
      REG_TEXT_START    = 2'd1,
      REG_TEXT_END      = 2'd2,
      REG_BLOCK_MODE    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [63:0] entry_address;
      logic [63:0] text_start;
      logic [63:0] text_end;
      logic        block_mode;
   } cfg_type;

   typedef struct packed {
      logic hit;
      logic rd;
      logic exc_done;
   } stage_ctl_type;

endpackage
`default_nettype wire

>>> rtl/bcm_req_if.sv
// Request channel carrying decoded trace items.
`default_nettype none
interface bcm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic        atom_executed;
   logic [63:0] target_address;
   logic        in_exception;
   logic        branch_pending;
   logic [7:0]  atoms_since_branch;
   logic [62:0] path_hash;
   logic [15:0] read_index;

   modport source (
      output valid, opcode, atom_executed, target_address, in_exception,
             branch_pending, atoms_since_branch, path_hash, read_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, atom_executed, target_address, in_exception,
             branch_pending, atoms_since_branch, path_hash, read_index,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/bcm_rsp_if.sv
// Response channel carrying one result per request.
`default_nettype none
interface bcm_rsp_if;
   logic        valid;
   logic        ready;
   logic        map_hit;
   logic [15:0] map_index;
   logic [7:0]  map_count;
   logic        exception_done;
   logic [7:0]  read_data;

   modport source (
      output valid, map_hit, map_index, map_count, exception_done, read_data,
      input  ready
   );
   modport sink (
      input  valid, map_hit, map_index, map_count, exception_done, read_data,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/branch_coverage_bitmap_update_top.sv
// Top level of the branch coverage bitmap update block.
`default_nettype none
// Keeps a 65536-entry map of 8-bit wrapping hit counters fed by decoded
// trace requests (atoms, branch targets, counter reads), one response per
// request. Requests are taken one per cycle unless the response channel
// stalls or the map is being cleared: the map lives in a single RAM with
// one write and one read port; a request reads its counter in the cycle it
// is accepted and the incremented value is written back as it leaves the
// first stage for the response register, with the last written entry
// forwarded so that back to back hits on one counter count correctly; the
// response register lets the next request enter while a response waits.
// After reset the map is cleared one entry per cycle, during which no
// request is accepted; configuration writes are taken at any time.
module branch_coverage_bitmap_update_top
   import bcm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   bcm_req_if.sink                       req_chan,
   bcm_rsp_if.source                     rsp_chan,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cfg_type cfg;

   bcm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [15:0]            hist_ff, hist_in, hist_next;
   logic [COUNT_BITS-1:0]  cnt_ff, cnt_in, cnt_next;
   logic [15:0]            prev_ff, prev_in;
   logic                   entry_seen_ff, entry_seen_in;
   logic [63:0]            irq_ff, irq_in;
   logic                   seen_now;
   logic                   in_range;
   logic [2:0]             atoms_clamped;
   logic [63:0]            branch_val;
   stage_ctl_type          ctl_in;
   logic [MAP_ADDR_BITS-1:0] idx_in;

   logic                   accept;
   logic                   s1_valid_ff;
   stage_ctl_type          s1_ctl_ff;
   logic [MAP_ADDR_BITS-1:0] s1_idx_ff;
   logic                   s1_adv;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [15:0]            rsp_index_ff;
   logic [7:0]             rsp_count_ff;
   logic                   rsp_exc_ff;
   logic [7:0]             rsp_read_ff;

   logic                   wr_valid_ff;
   logic [MAP_ADDR_BITS-1:0] wr_idx_ff;
   logic [7:0]             wr_val_ff;

   logic                   clr_active_ff;
   logic [MAP_ADDR_BITS-1:0] clr_addr_ff;

   logic [7:0]             ram_rdata;
   logic [7:0]             s1_data;
   logic [7:0]             s1_count;
   logic                   ram_we;
   logic [MAP_ADDR_BITS-1:0] ram_waddr;
   logic [7:0]             ram_wdata;

   assign s1_adv          = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !clr_active_ff && (!s1_valid_ff || s1_adv);
   assign accept          = req_chan.valid && req_chan.ready;

   assign seen_now  = entry_seen_ff || (req_chan.target_address == cfg.entry_address);
   assign in_range  = (req_chan.target_address >= cfg.text_start) &&
                      (req_chan.target_address <= cfg.text_end);
   assign atoms_clamped = (req_chan.atoms_since_branch > 8'd4) ? ATOM_CLAMP[2:0]
                                                              : req_chan.atoms_since_branch[2:0];
   assign branch_val = cfg.block_mode
                     ? req_chan.target_address + 64'(atoms_clamped) - 64'd1
                     : req_chan.target_address + {1'b0, req_chan.path_hash};
   assign hist_next  = {hist_ff[14:0], req_chan.atom_executed};
   assign cnt_next   = cnt_ff + COUNT_BITS'(1);

   always_comb begin
      hist_in       = hist_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      entry_seen_in = entry_seen_ff;
      irq_in        = irq_ff;
      ctl_in        = '0;
      idx_in        = '0;
      unique case (opcode_type'(req_chan.opcode))
         OP_ATOM: begin
            if (entry_seen_ff) begin
               if (cnt_next == COUNT_BITS'(ATOMS_PER_BLOCK)) begin
                  ctl_in.hit = 1'b1;
                  idx_in     = (hist_next ^ prev_ff) & IDX_MASK;
                  prev_in    = {1'b0, hist_next[15:1]};
                  hist_in    = '0;
                  cnt_in     = '0;
               end else begin
                  hist_in = hist_next;
                  cnt_in  = cnt_next;
               end
            end
         end
         OP_BRANCH: begin
            entry_seen_in = seen_now;
            if (req_chan.in_exception && (irq_ff == 64'd0)) begin
               irq_in = req_chan.target_address;
            end else if (seen_now && req_chan.branch_pending && in_range) begin
               if (req_chan.in_exception && (irq_ff == req_chan.target_address)) begin
                  irq_in          = '0;
                  ctl_in.exc_done = 1'b1;
               end else begin
                  ctl_in.hit = 1'b1;
                  idx_in     = (branch_val[15:0] ^ prev_ff) & IDX_MASK;
                  prev_in    = branch_val[16:1];
                  irq_in     = '0;
               end
            end
         end
         OP_READ: begin
            ctl_in.rd = 1'b1;
            idx_in    = req_chan.read_index;
         end
         OP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff       <= '0;
         cnt_ff        <= '0;
         prev_ff       <= '0;
         entry_seen_ff <= 1'b0;
         irq_ff        <= '0;
      end else if (accept) begin
         hist_ff       <= hist_in;
         cnt_ff        <= cnt_in;
         prev_ff       <= prev_in;
         entry_seen_ff <= entry_seen_in;
         irq_ff        <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_ctl_ff   <= '0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
         s1_ctl_ff   <= ctl_in;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff <= idx_in;
      end
   end

   assign s1_data  = (wr_valid_ff && (wr_idx_ff == s1_idx_ff)) ? wr_val_ff : ram_rdata;
   assign s1_count = s1_data + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_hit_ff   <= s1_ctl_ff.hit;
         rsp_index_ff <= s1_ctl_ff.hit ? s1_idx_ff : '0;
         rsp_count_ff <= s1_ctl_ff.hit ? s1_count : '0;
         rsp_exc_ff   <= s1_ctl_ff.exc_done;
         rsp_read_ff  <= s1_ctl_ff.rd ? s1_data : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.map_hit        = rsp_hit_ff;
   assign rsp_chan.map_index      = rsp_index_ff;
   assign rsp_chan.map_count      = rsp_count_ff;
   assign rsp_chan.exception_done = rsp_exc_ff;
   assign rsp_chan.read_data      = rsp_read_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (s1_adv && s1_ctl_ff.hit) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctl_ff.hit) begin
         wr_idx_ff <= s1_idx_ff;
         wr_val_ff <= s1_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + MAP_ADDR_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   assign ram_we    = clr_active_ff || (s1_adv && s1_ctl_ff.hit);
   assign ram_waddr = clr_active_ff ? clr_addr_ff : s1_idx_ff;
   assign ram_wdata = clr_active_ff ? 8'd0 : s1_count;

   bcm_ram #(
      .WIDTH (8),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (accept),
      .rd_addr    (idx_in),
      .rd_data_ff (ram_rdata)
   );

   a_no_request_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clr_active_ff |-> !req_chan.ready
   ) else $error("request accepted during map clear");

   a_forward_tracks_write: assert property (
      @(posedge clock) disable iff (reset) (s1_adv && s1_ctl_ff.hit) |=>
         (wr_valid_ff && (wr_idx_ff == $past(s1_idx_ff)) && (wr_val_ff == $past(s1_count)))
   ) else $error("forwarding register does not hold the last write");

   a_single_kind: assert property (
      @(posedge clock) disable iff (reset) s1_valid_ff |->
         $onehot0({s1_ctl_ff.hit, s1_ctl_ff.rd, s1_ctl_ff.exc_done})
   ) else $error("pipeline stage carries more than one result kind");

   a_irq_cleared: assert property (
      @(posedge clock) disable iff (reset) (accept && ctl_in.exc_done) |=> (irq_ff == 64'd0)
   ) else $error("return address not cleared after exception return");

   a_no_hit_write_idle: assert property (
      @(posedge clock) disable iff (reset) (!clr_active_ff && !s1_valid_ff) |-> !ram_we
   ) else $error("map written with no request in flight");

endmodule
`default_nettype wire

>>> rtl/bcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> rtl/bcm_csr.sv
// Configuration register file behind the APB-style port.
`default_nettype none
module bcm_csr
   import bcm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type       cfg_ff;
   reg_index_type reg_sel;
   logic          wr_en;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[CSR_ADDR_BITS-1:3]);
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.entry_address <= '0;
         cfg_ff.text_start    <= '0;
         cfg_ff.text_end      <= '1;
         cfg_ff.block_mode    <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_ENTRY_ADDRESS: cfg_ff.entry_address <= pwdata;
            REG_TEXT_START:    cfg_ff.text_start    <= pwdata;
            REG_TEXT_END:      cfg_ff.text_end      <= pwdata;
            REG_BLOCK_MODE:    cfg_ff.block_mode    <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_ENTRY_ADDRESS: prdata = cfg_ff.entry_address;
         REG_TEXT_START:    prdata = cfg_ff.text_start;
         REG_TEXT_END:      prdata = cfg_ff.text_end;
         REG_BLOCK_MODE:    prdata = {{(CSR_DATA_BITS-1){1'b0}}, cfg_ff.block_mode};
         default:           prdata = '0;
      endcase
   end

endmodule
`default_nettype wire
